/* design/fars_pkg.sv */
// ----------------------------------------------------------------------------
// fars_pkg: shared types and constants of the forward assembly scheduler
// Field widths, descriptor and result codes, the stored entry layout and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fars_pkg;

   localparam int CID_W   = 32;
   localparam int SIZE_W  = 20;
   localparam int TAG_W   = 16;
   localparam int LIMIT_W = 36;

   localparam int AREA_DEPTH_DEF = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 36'd16777216;

   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_USER_W = 3;

   // Descriptor kinds as they arrive and as they are stored.
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;
   localparam logic [1:0] KIND_RSVD  = 2'd3;

   // Result kinds.
   localparam logic [1:0] RES_READ   = 2'd0;
   localparam logic [1:0] RES_MARKER = 2'd1;
   localparam logic [1:0] RES_DATA   = 2'd2;
   localparam logic [1:0] RES_EMPTY  = 2'd3;

   // Source of an emitted result.
   localparam logic [1:0] SEL_ENTRY = 2'd0;
   localparam logic [1:0] SEL_READ  = 2'd1;
   localparam logic [1:0] SEL_EMPTY = 2'd2;

   typedef struct packed {
      logic              ready;
      logic [1:0]        kind;
      logic [TAG_W-1:0]  tag;
      logic [SIZE_W-1:0] size;
      logic [CID_W-1:0]  cid;
   } entry_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [CID_W-1:0]  cid;
      logic [TAG_W-1:0]  tag;
      logic [SIZE_W-1:0] size;
      logic              is_end;
   } result_type;

   typedef struct packed {
      logic       push_en;
      logic       head_rd;
      logic       release_head;
      logic       emit;
      logic [1:0] emit_sel;
      logic       flush;
      logic       mark_start;
      logic       mark_run;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic area_full;
      logic push_trigger;
      logic rd_marker;
      logic rd_ready;
      logic scan_done;
      logic emit_ok;
      logic flush_ok;
      logic pend_valid;
   } sts_type;

endpackage

`default_nettype wire

/* design/fars_ram.sv */
// ----------------------------------------------------------------------------
// fars_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fars_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* design/fars_datapath.sv */
// ----------------------------------------------------------------------------
// fars_datapath: assembly area storage, byte total and result staging
// Holds the descriptor ring in RAM, the head and fill count, the byte total
// and limit, the ready-marking scan and the two-deep result staging.
// ----------------------------------------------------------------------------
`default_nettype none

module fars_datapath #(
   parameter int AREA_DEPTH = fars_pkg::AREA_DEPTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire fars_pkg::cmd_type                    cmd,
   output fars_pkg::sts_type                         sts,
   input  wire logic [fars_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic [fars_pkg::REQ_USER_W-1:0]      req_tuser,
   input  wire logic                                 csr_wr_en,
   input  wire logic [fars_pkg::LIMIT_W-1:0]         csr_wr_data,
   input  wire logic                                 rsp_tready,
   output logic                                      rsp_tvalid,
   output logic      [fars_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic      [fars_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                      rsp_tlast
);

   import fars_pkg::*;

   localparam int AW  = $clog2(AREA_DEPTH);
   localparam int CW  = $clog2(AREA_DEPTH + 1);
   localparam int BW  = SIZE_W + CW;
   localparam int PAD = RSP_DATA_W - CID_W - TAG_W - SIZE_W;
   localparam int WIDTH_E = $bits(entry_type);
   localparam logic [AW:0]   DEPTH_X   = (AW+1)'(AREA_DEPTH);
   localparam logic [CW-1:0] COUNT_MAX = CW'(AREA_DEPTH);
   localparam logic [CW-1:0] COUNT_PRE = CW'(AREA_DEPTH - 1);

   function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + (AW+1)'(off);
      if (sum >= DEPTH_X) begin
         sum = sum - DEPTH_X;
      end
      return sum[AW-1:0];
   endfunction

   logic [AW-1:0]      head_ff,      head_in;
   logic [CW-1:0]      count_ff,     count_in;
   logic [BW-1:0]      bytes_ff,     bytes_in;
   logic [LIMIT_W-1:0] limit_ff,     limit_in;
   logic [CID_W-1:0]   cid_ff,       cid_in;
   logic [CW-1:0]      scan_k_ff,    scan_k_in;
   logic [AW-1:0]      scan_addr_ff, scan_addr_in;
   logic               scan_pend_ff, scan_pend_in;
   result_type         pend_ff,      pend_in;
   logic               pend_valid_ff, pend_valid_in;
   result_type         out_ff,       out_in;
   logic               out_last_ff,  out_last_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [CID_W-1:0]  req_cid;
   logic [SIZE_W-1:0] req_size;
   logic [TAG_W-1:0]  req_tag;
   logic [1:0]        req_kind;
   logic              req_is_data;
   logic [BW-1:0]     new_bytes;
   entry_type         new_entry;
   entry_type         rd_entry;
   entry_type         marked_entry;
   logic [WIDTH_E-1:0] rd_word;
   logic              mark_match;
   logic              scan_issue;
   logic [AW-1:0]     scan_rd_addr;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   entry_type         ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   result_type        new_res;
   logic              out_free;

   // Input beat fields; an unknown kind code is kept as a file end marker.
   assign req_cid     = req_tdata[CID_W-1:0];
   assign req_size    = req_tdata[CID_W+SIZE_W-1:CID_W];
   assign req_tag     = req_tdata[CID_W+SIZE_W+TAG_W-1:CID_W+SIZE_W];
   assign req_kind    = (req_tuser[2:1] == KIND_RSVD) ? KIND_END : req_tuser[2:1];
   assign req_is_data = (req_kind == KIND_DATA);

   assign new_bytes = bytes_ff + (req_is_data ? BW'(req_size) : BW'(0));

   always_comb begin
      new_entry       = '0;
      new_entry.kind  = req_kind;
      new_entry.tag   = req_tag;
      new_entry.cid   = req_cid;
      new_entry.size  = req_is_data ? req_size : '0;
      new_entry.ready = 1'b0;
   end

   assign rd_entry = entry_type'(rd_word);

   // Ready-marking scan: one read per cycle, matches written back next cycle.
   assign scan_issue   = (scan_k_ff != count_ff);
   assign scan_rd_addr = wrap_add(head_ff, scan_k_ff);
   assign mark_match   = scan_pend_ff && (rd_entry.kind == KIND_DATA) &&
                         (rd_entry.cid == cid_ff);

   always_comb begin
      marked_entry       = rd_entry;
      marked_entry.ready = 1'b1;
   end

   assign ram_wr_en   = cmd.push_en || mark_match;
   assign ram_wr_addr = cmd.push_en ? wrap_add(head_ff, count_ff) : scan_addr_ff;
   assign ram_wr_data = cmd.push_en ? new_entry : marked_entry;
   assign ram_rd_en   = cmd.head_rd || (cmd.mark_run && scan_issue);
   assign ram_rd_addr = cmd.head_rd ? head_ff : scan_rd_addr;

   fars_ram #(
      .WIDTH (WIDTH_E),
      .DEPTH (AREA_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_word)
   );

   always_comb begin
      new_res = '0;
      case (cmd.emit_sel)
         SEL_ENTRY: begin
            new_res.tag = rd_entry.tag;
            if (rd_entry.kind != KIND_DATA) begin
               new_res.kind   = RES_MARKER;
               new_res.is_end = (rd_entry.kind == KIND_END);
            end else begin
               new_res.kind = RES_DATA;
               new_res.cid  = rd_entry.cid;
               new_res.size = rd_entry.size;
            end
         end
         SEL_READ: begin
            new_res.kind = RES_READ;
            new_res.cid  = rd_entry.cid;
         end
         SEL_EMPTY: begin
            new_res.kind = RES_EMPTY;
         end
         default: begin
            new_res = '0;
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      bytes_in      = bytes_ff;
      limit_in      = csr_wr_en ? csr_wr_data : limit_ff;
      scan_k_in     = scan_k_ff;
      scan_pend_in  = cmd.mark_run && scan_issue;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (cmd.push_en) begin
         count_in = count_ff + CW'(1);
         bytes_in = new_bytes;
      end else if (cmd.release_head) begin
         head_in  = wrap_add(head_ff, CW'(1));
         count_in = count_ff - CW'(1);
         bytes_in = bytes_ff - BW'(rd_entry.size);
      end

      if (cmd.mark_start) begin
         scan_k_in = '0;
      end else if (cmd.mark_run && scan_issue) begin
         scan_k_in = scan_k_ff + CW'(1);
      end

      // A new result goes to the holding stage; the one held there moves to
      // the output, since it is now known not to be the last of its run.
      if (cmd.emit) begin
         pend_valid_in = 1'b1;
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_in = 1'b0;
         end
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
         rsp_valid_in  = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      cid_in       = (cmd.emit && (cmd.emit_sel == SEL_READ)) ? rd_entry.cid : cid_ff;
      scan_addr_in = (cmd.mark_run && scan_issue) ? scan_rd_addr : scan_addr_ff;
      pend_in      = cmd.emit ? new_res : pend_ff;
      out_in       = out_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit && pend_valid_ff) begin
         out_in      = pend_ff;
         out_last_in = 1'b0;
      end else if (cmd.flush) begin
         out_in      = pend_ff;
         out_last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= '0;
         bytes_ff      <= '0;
         limit_ff      <= LIMIT_RESET;
         scan_k_ff     <= '0;
         scan_pend_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         bytes_ff      <= bytes_in;
         limit_ff      <= limit_in;
         scan_k_ff     <= scan_k_in;
         scan_pend_ff  <= scan_pend_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cid_ff       <= cid_in;
      scan_addr_ff <= scan_addr_in;
      pend_ff      <= pend_in;
      out_ff       <= out_in;
      out_last_ff  <= out_last_in;
   end

   always_comb begin
      sts              = '0;
      sts.count_zero   = (count_ff == '0);
      sts.area_full    = (count_ff == COUNT_MAX);
      sts.push_trigger = (req_is_data && (LIMIT_W'(new_bytes) >= limit_ff)) ||
                         (count_ff == COUNT_PRE);
      sts.rd_marker    = (rd_entry.kind != KIND_DATA);
      sts.rd_ready     = rd_entry.ready;
      sts.scan_done    = !scan_issue && !scan_pend_ff;
      sts.emit_ok      = !pend_valid_ff || out_free;
      sts.flush_ok     = out_free;
      sts.pend_valid   = pend_valid_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD{1'b0}}, out_ff.size, out_ff.tag, out_ff.cid};
   assign rsp_tuser  = {out_ff.is_end, out_ff.kind};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

/* design/fars_ctrl.sv */
// ----------------------------------------------------------------------------
// fars_ctrl: sequencing of pushes and assembly rounds
// Accepts one request beat at a time and steps the datapath through marker
// release, the ready-marking scan, chunk release and the end of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module fars_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire logic              req_is_drain,
   output logic                   req_tready,
   input  wire fars_pkg::sts_type sts,
   output fars_pkg::cmd_type      cmd
);

   import fars_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_R1_READ  = 3'd1;
   localparam logic [2:0] ST_R1_CHECK = 3'd2;
   localparam logic [2:0] ST_MARK     = 3'd3;
   localparam logic [2:0] ST_R2_READ  = 3'd4;
   localparam logic [2:0] ST_R2_CHECK = 3'd5;
   localparam logic [2:0] ST_FINISH   = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_is_drain) begin
                  if (sts.count_zero) begin
                     cmd.emit     = 1'b1;
                     cmd.emit_sel = SEL_EMPTY;
                     state_in     = ST_FINISH;
                  end else begin
                     state_in = ST_R1_READ;
                  end
               end else if (!sts.area_full) begin
                  cmd.push_en = 1'b1;
                  if (sts.push_trigger) begin
                     state_in = ST_R1_READ;
                  end
               end
            end
         end
         ST_R1_READ: begin
            if (sts.count_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.head_rd = 1'b1;
               state_in    = ST_R1_CHECK;
            end
         end
         ST_R1_CHECK: begin
            if (sts.emit_ok) begin
               cmd.emit = 1'b1;
               if (sts.rd_marker) begin
                  cmd.emit_sel     = SEL_ENTRY;
                  cmd.release_head = 1'b1;
                  state_in         = ST_R1_READ;
               end else begin
                  cmd.emit_sel   = SEL_READ;
                  cmd.mark_start = 1'b1;
                  state_in       = ST_MARK;
               end
            end
         end
         ST_MARK: begin
            cmd.mark_run = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_R2_READ;
            end
         end
         ST_R2_READ: begin
            if (sts.count_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.head_rd = 1'b1;
               state_in    = ST_R2_CHECK;
            end
         end
         ST_R2_CHECK: begin
            if (sts.rd_marker || sts.rd_ready) begin
               if (sts.emit_ok) begin
                  cmd.emit         = 1'b1;
                  cmd.emit_sel     = SEL_ENTRY;
                  cmd.release_head = 1'b1;
                  state_in         = ST_R2_READ;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // The held result is the last of the run and leaves with tlast.
            if (!sts.pend_valid) begin
               state_in = ST_IDLE;
            end else if (sts.flush_ok) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* design/forward_assembly_restore_scheduler.sv */
// ----------------------------------------------------------------------------
// forward_assembly_restore_scheduler: forward assembly area restore scheduler
// Top level: request and result streams, limit register, controller and
// datapath.
// ----------------------------------------------------------------------------
// Descriptors are pushed one beat at a time into a ring of AREA_DEPTH
// entries held in a single RAM. A round, started when the byte total
// reaches the limit, when a push fills the area, or by a drain beat, first
// releases the markers at the head (each a RAM read of the head, then the
// release), then issues the container read request for the chunk left at
// the head and makes the ready-marking pass, which walks every stored entry
// through the RAM's one read port; it then releases markers and ready
// chunks from the head until the look at the head finds neither, and
// closes the run. Stalls on the result side can hold any release and the
// close. A new request beat is taken once the last result of a run has
// moved to the output register, even while that result still waits there.
// The limit register may be written only when no run is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module forward_assembly_restore_scheduler #(
   parameter int AREA_DEPTH = fars_pkg::AREA_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // container_id [31:0], chunk_size [51:32], chunk_tag [67:52], zeros above
   input  wire logic [fars_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type [0], entry_kind [2:1]
   input  wire logic [fars_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // out_container_id [31:0], out_tag [47:32], out_size [67:48], zeros above
   output logic      [fars_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // result_kind [1:0], marker_is_end [2]
   output logic      [fars_pkg::RSP_USER_W-1:0] rsp_tuser,
   // last_of_run
   output logic                                 rsp_tlast,
   input  wire logic                            csr_wr_en,
   input  wire logic [fars_pkg::LIMIT_W-1:0]    csr_wr_data
);

   import fars_pkg::*;

   cmd_type cmd;
   sts_type sts;

   fars_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_is_drain (req_tuser[0]),
      .req_tready   (req_tready),
      .sts          (sts),
      .cmd          (cmd)
   );

   fars_datapath #(
      .AREA_DEPTH (AREA_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

/* design/fars_checker.sv */
// ----------------------------------------------------------------------------
// fars_checker: port-level checks of the restore scheduler
// Watches the result stream of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module fars_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [fars_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [fars_pkg::RSP_USER_W-1:0] rsp_tuser,
   input wire logic                            rsp_tlast
);

   import fars_pkg::*;

   // A stalled result beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // An empty report is the only result of its drain.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == RES_EMPTY) |-> rsp_tlast)
      else $error("area empty report without tlast");

   // A container read always releases at least the chunk at the head after it.
   a_read_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == RES_READ) |-> !rsp_tlast)
      else $error("container read closed a run");

   // The end flag belongs to released markers only.
   a_end_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> (rsp_tuser[1:0] == RES_MARKER))
      else $error("end flag on a result that is not a marker");

endmodule

bind forward_assembly_restore_scheduler fars_checker u_fars_checker (.*);

`default_nettype wire

/* tb/tb_forward_assembly_restore_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_forward_assembly_restore_scheduler: stream-level test of the scheduler
// Descriptor and drain beats go in through a queue-fed driver with random
// gaps. A scoreboard keeps its own copy of the assembly area, works out the
// reads and releases that each accepted beat causes, and checks every result
// beat field by field. The limit register is moved between phases, and the
// result side is held off once for a long stretch to make the block back up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_forward_assembly_restore_scheduler;

   import fars_pkg::*;

   localparam int          DEPTH         = AREA_DEPTH_DEF;
   localparam logic        REQ_PUSH      = 1'b0;
   localparam logic        REQ_DRAIN     = 1'b1;
   localparam int          CYCLE_LIMIT   = 1000000;
   localparam int          SETTLE_CYCLES = 200;
   localparam int          HOLD_CYCLES   = 400;
   localparam logic [35:0] LIMIT_MAX     = 36'hF_FFFF_FFFF;

   typedef struct packed {
      logic              op;
      logic [1:0]        kind;
      logic [CID_W-1:0]  cid;
      logic [SIZE_W-1:0] size;
      logic [TAG_W-1:0]  tag;
   } descriptor_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [CID_W-1:0]  cid;
      logic [TAG_W-1:0]  tag;
      logic [SIZE_W-1:0] size;
      logic              is_end;
      logic              last;
   } release_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wr_en;
   logic [LIMIT_W-1:0]    csr_wr_data;

   // Mirror of the assembly area.
   logic [CID_W-1:0]  area_cid   [DEPTH];
   logic [SIZE_W-1:0] area_len   [DEPTH];
   logic [TAG_W-1:0]  area_tag   [DEPTH];
   logic [1:0]        area_kind  [DEPTH];
   logic              area_ready [DEPTH];
   int unsigned       area_head;
   int unsigned       area_count;
   longint unsigned   area_bytes;
   longint unsigned   limit_bytes;

   descriptor_type beat_queue[$];
   release_type    run_results[$];
   release_type    awaited_releases[$];
   release_type    seen;

   descriptor_type next_beat;
   logic        req_fire;
   logic        rsp_fire;
   logic        req_calm;
   logic        rsp_calm;
   int          req_gap;
   int          rsp_stall;
   int          hold_left;
   logic        hold_arm;
   logic        hold_done;
   int          error_count;
   int          cycle_count;
   logic [CID_W-1:0] cid_pool [3];

   forward_assembly_restore_scheduler dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %0h, expected %0h at cycle %0d",
               what, got, want, cycle_count);
      error_count++;
   endtask

   // ---------------------------------------------------------------- predictor

   function automatic void note_result(logic [1:0] kind, logic [CID_W-1:0] cid,
                                       logic [TAG_W-1:0] tag,
                                       logic [SIZE_W-1:0] size, logic is_end);
      release_type r;
      r.kind   = kind;
      r.cid    = cid;
      r.tag    = tag;
      r.size   = size;
      r.is_end = is_end;
      r.last   = 1'b0;
      run_results.push_back(r);
   endfunction

   // Releases the head if it is a marker, or a ready data chunk when allowed.
   function automatic bit release_front(bit ready_ok);
      int unsigned p;
      if (area_count == 0)
         return 1'b0;
      p = area_head;
      if (area_kind[p] != KIND_DATA) begin
         note_result(RES_MARKER, '0, area_tag[p], '0, area_kind[p] == KIND_END);
      end else if (ready_ok && area_ready[p]) begin
         note_result(RES_DATA, area_cid[p], area_tag[p], area_len[p], 1'b0);
         area_bytes -= area_len[p];
      end else begin
         return 1'b0;
      end
      area_head = (area_head + 1) % DEPTH;
      area_count--;
      return 1'b1;
   endfunction

   function automatic void assemble_round();
      int unsigned      p;
      logic [CID_W-1:0] wanted;
      while (release_front(1'b0))
         ;
      if (area_count == 0)
         return;
      wanted = area_cid[area_head];
      note_result(RES_READ, wanted, '0, '0, 1'b0);
      for (int unsigned k = 0; k < area_count; k++) begin
         p = (area_head + k) % DEPTH;
         if (area_kind[p] == KIND_DATA && area_cid[p] == wanted)
            area_ready[p] = 1'b1;
      end
      while (release_front(1'b1))
         ;
   endfunction

   function automatic void predict_releases(descriptor_type d);
      logic [1:0]  kind;
      int unsigned p;
      bit          trigger;
      release_type r;
      run_results.delete();
      trigger = 1'b0;
      if (d.op == REQ_DRAIN) begin
         if (area_count == 0)
            note_result(RES_EMPTY, '0, '0, '0, 1'b0);
         else
            assemble_round();
      end else if (area_count < DEPTH) begin
         kind = (d.kind == KIND_RSVD) ? KIND_END : d.kind;
         p = (area_head + area_count) % DEPTH;
         area_cid[p]   = d.cid;
         area_len[p]   = (kind == KIND_DATA) ? d.size : '0;
         area_tag[p]   = d.tag;
         area_kind[p]  = kind;
         area_ready[p] = 1'b0;
         area_count++;
         if (kind == KIND_DATA) begin
            area_bytes += d.size;
            if (area_bytes >= limit_bytes)
               trigger = 1'b1;
         end
         if (area_count >= DEPTH)
            trigger = 1'b1;
         if (trigger)
            assemble_round();
      end
      if (run_results.size() > 0) begin
         r = run_results.pop_back();
         r.last = 1'b1;
         run_results.push_back(r);
      end
      while (run_results.size() > 0)
         awaited_releases.push_back(run_results.pop_front());
   endfunction

   // ----------------------------------------------------------------- monitor

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", awaited_releases.size());
         $display("** forward_assembly_restore_scheduler: FAILED **");
         $finish;
      end else begin
         req_fire <= !reset && req_tvalid && req_tready;
         rsp_fire <= !reset && rsp_tvalid && rsp_tready;
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (awaited_releases.size() == 0) begin
               report_mismatch("result beat with nothing outstanding",
                               {rsp_tuser, rsp_tdata[31:0]}, '0);
            end else begin
               seen = awaited_releases.pop_front();
               if (rsp_tuser[1:0] !== seen.kind)
                  report_mismatch("result_kind", rsp_tuser[1:0], seen.kind);
               if (rsp_tdata[31:0] !== seen.cid)
                  report_mismatch("out_container_id", rsp_tdata[31:0], seen.cid);
               if (rsp_tdata[47:32] !== seen.tag)
                  report_mismatch("out_tag", rsp_tdata[47:32], seen.tag);
               if (rsp_tdata[67:48] !== seen.size)
                  report_mismatch("out_size", rsp_tdata[67:48], seen.size);
               if (rsp_tuser[2] !== seen.is_end)
                  report_mismatch("marker_is_end", rsp_tuser[2], seen.is_end);
               if (rsp_tlast !== seen.last)
                  report_mismatch("last_of_run", rsp_tlast, seen.last);
            end
         end
         // A result never belongs to a beat taken at the same edge.
         if (!reset && req_tvalid && req_tready)
            predict_releases('{op: req_tuser[0], kind: req_tuser[2:1],
                               cid: req_tdata[31:0], size: req_tdata[51:32],
                               tag: req_tdata[67:52]});
      end
   end

   // ------------------------------------------------------------------ driver

   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && !req_fire) begin
            // beat still on offer
         end else if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap--;
         end else if (beat_queue.size() > 0) begin
            next_beat = beat_queue.pop_front();
            req_tdata  <= {4'b0, next_beat.tag, next_beat.size, next_beat.cid};
            req_tuser  <= {next_beat.kind, next_beat.op};
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 15) == 0)
               req_calm = !req_calm;
            req_gap = req_calm ? 0 : int'($urandom_range(0, 9));
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   always @(negedge clock) begin
      if (rsp_fire) begin
         if ($urandom_range(0, 15) == 0)
            rsp_calm = !rsp_calm;
         rsp_stall = rsp_calm ? 0 : int'($urandom_range(0, 9));
      end
      if (hold_arm && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic void add_beat(logic op, logic [1:0] kind, logic [CID_W-1:0] cid,
                                    logic [SIZE_W-1:0] size, logic [TAG_W-1:0] tag);
      descriptor_type d;
      d.op   = op;
      d.kind = kind;
      d.cid  = cid;
      d.size = size;
      d.tag  = tag;
      beat_queue.push_back(d);
   endfunction

   function automatic logic [SIZE_W-1:0] draw_size();
      if ($urandom_range(0, 3) == 0)
         return SIZE_W'($urandom_range(0, 255));
      return SIZE_W'($urandom_range(0, 20'hF_FFFF));
   endfunction

   function automatic logic [CID_W-1:0] draw_cid();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly whole files (start, chunks from a few containers, end), with
   // drains and stray beats mixed in.
   function automatic void queue_files(int count, int drain_pct);
      int made;
      int pick;
      int chunks;
      made = 0;
      while (made < count) begin
         pick = int'($urandom_range(0, 99));
         if (pick < drain_pct) begin
            add_beat(REQ_DRAIN, 2'($urandom_range(0, 3)), $urandom,
                     SIZE_W'($urandom), TAG_W'($urandom));
            made++;
         end else if (pick < drain_pct + 4) begin
            add_beat(REQ_PUSH, 2'($urandom_range(0, 3)), draw_cid(), draw_size(),
                     TAG_W'($urandom));
            made++;
         end else begin
            for (int i = 0; i < 3; i++)
               cid_pool[i] = draw_cid();
            chunks = int'($urandom_range(1, 6));
            add_beat(REQ_PUSH, KIND_START, $urandom, SIZE_W'($urandom), TAG_W'($urandom));
            for (int i = 0; i < chunks; i++)
               add_beat(REQ_PUSH, KIND_DATA, cid_pool[$urandom_range(0, 2)],
                        draw_size(), TAG_W'($urandom));
            add_beat(REQ_PUSH, ($urandom_range(0, 7) == 0) ? KIND_RSVD : KIND_END,
                     $urandom, SIZE_W'($urandom), TAG_W'($urandom));
            made += chunks + 2;
         end
      end
   endfunction

   // Waits until every beat has gone in and every result has come out, then
   // lets any round still at work on a silent push finish.
   task automatic wait_idle();
      do
         @(negedge clock);
      while (beat_queue.size() != 0 || req_tvalid || awaited_releases.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      limit_bytes = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_fire    = 1'b0;
      rsp_fire    = 1'b0;
      req_calm    = 1'b0;
      rsp_calm    = 1'b0;
      req_gap     = 0;
      rsp_stall   = 0;
      hold_left   = 0;
      hold_arm    = 1'b0;
      hold_done   = 1'b0;
      error_count = 0;
      cycle_count = 0;
      area_head   = 0;
      area_count  = 0;
      area_bytes  = 0;
      limit_bytes = LIMIT_RESET;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty drain, both marker kinds, the reserved kind, extreme fields and
      // a round that stops at a chunk of another container.
      add_beat(REQ_DRAIN, 2'b11, '1, '1, '1);
      add_beat(REQ_PUSH, KIND_START, '1, '1, 16'hFFFF);
      add_beat(REQ_PUSH, KIND_DATA, '1, 20'hF_FFFF, 16'h0000);
      add_beat(REQ_PUSH, KIND_DATA, '0, 20'h0_0000, 16'hFFFF);
      add_beat(REQ_PUSH, KIND_END, '0, '0, 16'h1234);
      add_beat(REQ_PUSH, KIND_RSVD, 32'h5A5A_A5A5, 20'hA_5A5A, 16'h5678);
      add_beat(REQ_PUSH, KIND_DATA, '1, 20'h0_0001, 16'hAAAA);
      add_beat(REQ_DRAIN, KIND_DATA, '0, '0, '0);
      add_beat(REQ_DRAIN, KIND_DATA, '0, '0, '0);
      add_beat(REQ_DRAIN, KIND_DATA, '0, '0, '0);

      // Smallest limit: a zero-size chunk stays, any other chunk triggers.
      write_limit(36'd1);
      add_beat(REQ_PUSH, KIND_DATA, 32'h0000_0005, 20'h0_0000, 16'h0101);
      add_beat(REQ_PUSH, KIND_START, 32'h0000_0007, 20'h0_0003, 16'h0202);
      add_beat(REQ_PUSH, KIND_DATA, 32'h0000_0007, 20'h0_0003, 16'h0303);
      add_beat(REQ_DRAIN, KIND_DATA, '0, '0, '0);
      add_beat(REQ_DRAIN, KIND_DATA, '0, '0, '0);

      // Largest limit: only a full area or a drain starts a round.
      write_limit(LIMIT_MAX);
      queue_files(36, 2);

      write_limit(36'($urandom_range(1000000, 6000000)));
      queue_files(20, 8);

      write_limit(LIMIT_RESET);
      queue_files(15, 5);

      // Every chunk of nonzero size triggers while the result side is held off.
      write_limit(36'd1);
      @(posedge clock);
      hold_arm = 1'b1;
      queue_files(20, 5);

      write_limit(36'($urandom_range(1, 2097152)));
      queue_files(15, 10);
      for (int i = 0; i < DEPTH + 4; i++)
         add_beat(REQ_DRAIN, 2'($urandom_range(0, 3)), $urandom,
                  SIZE_W'($urandom), TAG_W'($urandom));

      wait_idle();
      if (error_count == 0)
         $display("** forward_assembly_restore_scheduler: PASSED **");
      else
         $display("** forward_assembly_restore_scheduler: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
